// ----- src/sgbs_pkg.sv -----
`timescale 1ns / 1ps

package sgbs_pkg;

    localparam int GRID_COLUMNS = 64;
    localparam int GRID_ROWS    = 64;
    localparam int GRID_DEPTH   = GRID_COLUMNS * GRID_ROWS;
    localparam int ADDR_W       = $clog2(GRID_DEPTH);
    localparam int VALUE_W      = 32;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [VALUE_W-1:0] CELL_SIZE_RESET = 32'h0001_0000;
    localparam logic [64:0]        HALF_CELL_Q32   = 65'h0_8000_0000;

    localparam logic [1:0] OP_WRITE_H = 2'd0;
    localparam logic [1:0] OP_WRITE_V = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_CELL_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CELL_HEIGHT = 1'b1;

    localparam logic [1:0] CORNER_A = 2'd0;
    localparam logic [1:0] CORNER_B = 2'd1;
    localparam logic [1:0] CORNER_E = 2'd2;
    localparam logic [1:0] CORNER_G = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_LOCATE,
        ST_READ,
        ST_DRAIN,
        ST_ROW0,
        ST_ROW1,
        ST_WAIT_R0,
        ST_WAIT_R1,
        ST_WAIT_COL,
        ST_DONE
    } state_t;

    function automatic logic [ADDR_W-1:0] grid_addr(input logic [31:0] c,
                                                    input logic [31:0] r);
        logic [31:0] full;
        full = c * 32'(GRID_ROWS) + r;
        return full[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] corner_addr(input logic [ADDR_W-1:0] base,
                                                      input logic [1:0] idx);
        logic [ADDR_W-1:0] a;
        case (idx)
            CORNER_A: a = base;
            CORNER_B: a = base + ADDR_W'(GRID_ROWS);
            CORNER_E: a = base + ADDR_W'(1);
            CORNER_G: a = base + ADDR_W'(GRID_ROWS + 1);
            default:  a = base;
        endcase
        return a;
    endfunction

endpackage

// ----- src/staggered_grid_bilinear_sampler.sv -----
`timescale 1ns / 1ps

// Write item: stored in its grid at the clock edge that accepts it.
// Query item: runs the 64-step quotient-bit divider, then the four reads per single-port
// grid and the blending; an out-of-range query skips the reads and the blending.
// One query in flight; writes follow each other every cycle while no query is in flight.
// Reset clears control and sets both cell sizes to 1.0; grid contents stay
// undefined until written.
module staggered_grid_bilinear_sampler (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [sgbs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         op,
    input  logic [5:0]                         column,
    input  logic [5:0]                         row,
    input  logic signed [31:0]                 entry_value,
    input  logic [31:0]                        query_x,
    input  logic [31:0]                        query_y,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [31:0]                 horizontal_velocity,
    output logic signed [31:0]                 vertical_velocity,
    output logic                               out_of_range
);

    sgbs_pkg::state_t state_reg;
    sgbs_pkg::state_t state_next;

    logic [31:0] cell_width_reg;
    logic [31:0] cell_height_reg;
    logic [31:0] dx_reg;
    logic [31:0] dy_reg;

    logic        accept;
    logic        out_free;
    logic        write_ok;
    logic        u_we;
    logic        v_we;
    logic        div_start;
    logic        div_x_busy;
    logic        div_y_busy;
    logic [63:0] qx;
    logic [63:0] qy;

    logic [64:0] sx;
    logic [64:0] sy;
    logic [32:0] ucx;
    logic [32:0] ucy;
    logic [32:0] vcx;
    logic [32:0] vcy;
    logic        fits;

    logic                        oor_reg;
    logic [sgbs_pkg::ADDR_W-1:0] u_base_reg;
    logic [sgbs_pkg::ADDR_W-1:0] v_base_reg;
    logic [31:0]                 utx_reg;
    logic [31:0]                 uty_reg;
    logic [31:0]                 vtx_reg;
    logic [31:0]                 vty_reg;

    logic [1:0]  rd_cnt_reg;
    logic        cap_valid_reg;
    logic [1:0]  cap_idx_reg;
    logic [31:0] u_corner_reg [4];
    logic [31:0] v_corner_reg [4];

    logic [sgbs_pkg::ADDR_W-1:0] wr_addr;
    logic [sgbs_pkg::ADDR_W-1:0] u_addr;
    logic [sgbs_pkg::ADDR_W-1:0] v_addr;
    logic [31:0]                 u_rdata;
    logic [31:0]                 v_rdata;

    logic        lerp_start;
    logic [31:0] u_lp;
    logic [31:0] u_lq;
    logic [31:0] u_lt;
    logic [31:0] v_lp;
    logic [31:0] v_lq;
    logic [31:0] v_lt;
    logic        u_lvalid;
    logic        v_lvalid;
    logic [31:0] u_lres;
    logic [31:0] v_lres;
    logic [31:0] u_r0_reg;
    logic [31:0] v_r0_reg;
    logic [31:0] u_res_reg;
    logic [31:0] v_res_reg;

    logic        out_valid_reg;
    logic        out_load;
    logic [31:0] out_h_reg;
    logic [31:0] out_v_reg;
    logic        out_oor_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_width_reg  <= sgbs_pkg::CELL_SIZE_RESET;
            cell_height_reg <= sgbs_pkg::CELL_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sgbs_pkg::CFG_CELL_WIDTH:  cell_width_reg  <= cfg_data;
                sgbs_pkg::CFG_CELL_HEIGHT: cell_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input side
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == sgbs_pkg::ST_IDLE) ||
                       ((state_reg == sgbs_pkg::ST_DONE) && out_free);
    assign accept    = in_valid && in_ready;
    assign write_ok  = (32'(column) < 32'(sgbs_pkg::GRID_COLUMNS)) &&
                       (32'(row) < 32'(sgbs_pkg::GRID_ROWS));
    assign u_we      = accept && (op == sgbs_pkg::OP_WRITE_H) && write_ok;
    assign v_we      = accept && (op == sgbs_pkg::OP_WRITE_V) && write_ok;
    assign div_start = accept && (op == sgbs_pkg::OP_QUERY);
    assign wr_addr   = sgbs_pkg::grid_addr(32'(column), 32'(row));

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            dx_reg <= cell_width_reg;
            dy_reg <= cell_height_reg;
        end
    end

    sgbs_divider u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (query_x),
        .divisor  (cell_width_reg),
        .busy     (div_x_busy),
        .quotient (qx)
    );

    sgbs_divider u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (query_y),
        .divisor  (cell_height_reg),
        .busy     (div_y_busy),
        .quotient (qy)
    );

    // cell location; the half-cell shift adds one half to the Q32 quotient
    always_comb
    begin
        sx   = {1'b0, qx} + sgbs_pkg::HALF_CELL_Q32;
        sy   = {1'b0, qy} + sgbs_pkg::HALF_CELL_Q32;
        ucx  = {1'b0, qx[63:32]};
        ucy  = sy[64:32];
        vcx  = sx[64:32];
        vcy  = {1'b0, qy[63:32]};
        fits = (ucx < 33'(sgbs_pkg::GRID_COLUMNS - 1)) &&
               (ucy < 33'(sgbs_pkg::GRID_ROWS - 1)) &&
               (vcx < 33'(sgbs_pkg::GRID_COLUMNS - 1)) &&
               (vcy < 33'(sgbs_pkg::GRID_ROWS - 1)) &&
               (dx_reg != 32'd0) && (dy_reg != 32'd0);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == sgbs_pkg::ST_LOCATE)
        begin
            oor_reg    <= !fits;
            u_base_reg <= sgbs_pkg::grid_addr(ucx[31:0], ucy[31:0]);
            v_base_reg <= sgbs_pkg::grid_addr(vcx[31:0], vcy[31:0]);
            utx_reg    <= qx[31:0];
            uty_reg    <= sy[31:0];
            vtx_reg    <= sx[31:0];
            vty_reg    <= qy[31:0];
        end
    end

    // grid stores
    assign u_addr = (state_reg == sgbs_pkg::ST_READ) ?
                    sgbs_pkg::corner_addr(u_base_reg, rd_cnt_reg) : wr_addr;
    assign v_addr = (state_reg == sgbs_pkg::ST_READ) ?
                    sgbs_pkg::corner_addr(v_base_reg, rd_cnt_reg) : wr_addr;

    sgbs_ram #(
        .WIDTH (sgbs_pkg::VALUE_W),
        .DEPTH (sgbs_pkg::GRID_DEPTH)
    ) u_grid_h (
        .clk   (clk),
        .we    (u_we),
        .addr  (u_addr),
        .wdata (entry_value),
        .rdata (u_rdata)
    );

    sgbs_ram #(
        .WIDTH (sgbs_pkg::VALUE_W),
        .DEPTH (sgbs_pkg::GRID_DEPTH)
    ) u_grid_v (
        .clk   (clk),
        .we    (v_we),
        .addr  (v_addr),
        .wdata (entry_value),
        .rdata (v_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_cnt_reg    <= '0;
            cap_valid_reg <= 1'b0;
        end
        else
        begin
            cap_valid_reg <= (state_reg == sgbs_pkg::ST_READ);
            if (state_reg == sgbs_pkg::ST_READ)
            begin
                rd_cnt_reg <= rd_cnt_reg + 2'd1;
            end
            else
            begin
                rd_cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cap_idx_reg <= rd_cnt_reg;
        if (cap_valid_reg)
        begin
            u_corner_reg[cap_idx_reg] <= u_rdata;
            v_corner_reg[cap_idx_reg] <= v_rdata;
        end
    end

    // blending: two rows along x, then the column along y
    always_comb
    begin
        lerp_start = 1'b0;
        u_lp = u_corner_reg[sgbs_pkg::CORNER_A];
        u_lq = u_corner_reg[sgbs_pkg::CORNER_B];
        u_lt = utx_reg;
        v_lp = v_corner_reg[sgbs_pkg::CORNER_A];
        v_lq = v_corner_reg[sgbs_pkg::CORNER_B];
        v_lt = vtx_reg;
        case (state_reg)
            sgbs_pkg::ST_ROW0:
            begin
                lerp_start = 1'b1;
            end
            sgbs_pkg::ST_ROW1:
            begin
                lerp_start = 1'b1;
                u_lp = u_corner_reg[sgbs_pkg::CORNER_E];
                u_lq = u_corner_reg[sgbs_pkg::CORNER_G];
                v_lp = v_corner_reg[sgbs_pkg::CORNER_E];
                v_lq = v_corner_reg[sgbs_pkg::CORNER_G];
            end
            sgbs_pkg::ST_WAIT_R1:
            begin
                lerp_start = u_lvalid;
                u_lp = u_r0_reg;
                u_lq = u_lres;
                u_lt = uty_reg;
                v_lp = v_r0_reg;
                v_lq = v_lres;
                v_lt = vty_reg;
            end
            default: ;
        endcase
    end

    sgbs_lerp u_lerp_h (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (lerp_start),
        .p            (u_lp),
        .q            (u_lq),
        .t            (u_lt),
        .result_valid (u_lvalid),
        .result       (u_lres)
    );

    sgbs_lerp u_lerp_v (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (lerp_start),
        .p            (v_lp),
        .q            (v_lq),
        .t            (v_lt),
        .result_valid (v_lvalid),
        .result       (v_lres)
    );

    always_ff @(posedge clk)
    begin
        if ((state_reg == sgbs_pkg::ST_WAIT_R0) && u_lvalid)
        begin
            u_r0_reg <= u_lres;
            v_r0_reg <= v_lres;
        end
        if ((state_reg == sgbs_pkg::ST_LOCATE) && !fits)
        begin
            u_res_reg <= '0;
            v_res_reg <= '0;
        end
        else if ((state_reg == sgbs_pkg::ST_WAIT_COL) && u_lvalid)
        begin
            u_res_reg <= u_lres;
            v_res_reg <= v_lres;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sgbs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        case (state_reg)
            sgbs_pkg::ST_IDLE:
            begin
                if (div_start)
                begin
                    state_next = sgbs_pkg::ST_DIVIDE;
                end
            end
            sgbs_pkg::ST_DIVIDE:
            begin
                if (!div_x_busy && !div_y_busy)
                begin
                    state_next = sgbs_pkg::ST_LOCATE;
                end
            end
            sgbs_pkg::ST_LOCATE:
            begin
                state_next = fits ? sgbs_pkg::ST_READ : sgbs_pkg::ST_DONE;
            end
            sgbs_pkg::ST_READ:
            begin
                if (rd_cnt_reg == sgbs_pkg::CORNER_G)
                begin
                    state_next = sgbs_pkg::ST_DRAIN;
                end
            end
            sgbs_pkg::ST_DRAIN:
            begin
                state_next = sgbs_pkg::ST_ROW0;
            end
            sgbs_pkg::ST_ROW0:
            begin
                state_next = sgbs_pkg::ST_ROW1;
            end
            sgbs_pkg::ST_ROW1:
            begin
                state_next = sgbs_pkg::ST_WAIT_R0;
            end
            sgbs_pkg::ST_WAIT_R0:
            begin
                if (u_lvalid)
                begin
                    state_next = sgbs_pkg::ST_WAIT_R1;
                end
            end
            sgbs_pkg::ST_WAIT_R1:
            begin
                if (u_lvalid)
                begin
                    state_next = sgbs_pkg::ST_WAIT_COL;
                end
            end
            sgbs_pkg::ST_WAIT_COL:
            begin
                if (u_lvalid)
                begin
                    state_next = sgbs_pkg::ST_DONE;
                end
            end
            sgbs_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = div_start ? sgbs_pkg::ST_DIVIDE : sgbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sgbs_pkg::ST_IDLE;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_h_reg   <= u_res_reg;
            out_v_reg   <= v_res_reg;
            out_oor_reg <= oor_reg;
        end
    end

    assign out_valid           = out_valid_reg;
    assign horizontal_velocity = out_h_reg;
    assign vertical_velocity   = out_v_reg;
    assign out_of_range        = out_oor_reg;

endmodule

// ----- src/sgbs_ram.sv -----
`timescale 1ns / 1ps

module sgbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/sgbs_divider.sv -----
`timescale 1ns / 1ps

// floor(p * 2^32 / d), one quotient bit per cycle
module sgbs_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [63:0] quotient
);

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [63:0] sh_reg;
    logic [31:0] div_reg;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        qbit;

    always_comb
    begin
        trial = {rem_reg, sh_reg[63]};
        diff  = trial - {1'b0, div_reg};
        qbit  = (trial >= {1'b0, div_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            sh_reg  <= {dividend, 32'b0};
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? diff[31:0] : trial[31:0];
            sh_reg  <= {sh_reg[62:0], qbit};
        end
    end

    assign busy     = busy_reg;
    assign quotient = sh_reg;

endmodule

// ----- src/sgbs_lerp.sv -----
`timescale 1ns / 1ps

// p + round((q - p) * t / 2^32), ties up; three stages
module sgbs_lerp (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] p,
    input  logic [31:0] q,
    input  logic [31:0] t,
    output logic        result_valid,
    output logic [31:0] result
);

    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;
    logic [32:0] diff_reg;
    logic [31:0] t1_reg;
    logic [31:0] p1_reg;
    logic [31:0] p2_reg;
    logic [65:0] prod_reg;
    logic [31:0] res_reg;
    logic [65:0] prod_next;
    logic [65:0] rnd;
    logic [33:0] sum;

    always_comb
    begin
        prod_next = $signed({1'b0, t1_reg}) * $signed(diff_reg);
        rnd       = prod_reg + 66'h0_8000_0000;
        sum       = {{2{p2_reg[31]}}, p2_reg} + rnd[65:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= {q[31], q} - {p[31], p};
        t1_reg   <= t;
        p1_reg   <= p;
        prod_reg <= prod_next;
        p2_reg   <= p1_reg;
        res_reg  <= sum[31:0];
    end

    assign result_valid = v3_reg;
    assign result       = res_reg;

endmodule

// ----- sim/staggered_grid_bilinear_sampler_tb.sv -----
`timescale 1ns / 1ps

module staggered_grid_bilinear_sampler_tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD = 400;

    typedef struct {
        logic signed [31:0] h;
        logic signed [31:0] v;
        logic               oor;
    } sample_t;

    class velocity_board;
        logic [31:0] cell_w;
        logic [31:0] cell_h;
        logic [31:0] h_grid [sgbs_pkg::GRID_DEPTH];
        logic [31:0] v_grid [sgbs_pkg::GRID_DEPTH];
        bit          h_set [sgbs_pkg::GRID_DEPTH];
        bit          v_set [sgbs_pkg::GRID_DEPTH];
        sample_t     due [$];
        int          errors;

        function new();
            cell_w = sgbs_pkg::CELL_SIZE_RESET;
            cell_h = sgbs_pkg::CELL_SIZE_RESET;
            errors = 0;
        endfunction

        function void set_reg(logic [sgbs_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] d);
            if (idx == sgbs_pkg::CFG_CELL_WIDTH)
                cell_w = d;
            else
                cell_h = d;
        endfunction

        function void axis_plain(longint unsigned p, longint unsigned d,
                                 output longint unsigned c, output longint unsigned t);
            c = p / d;
            t = ((p % d) << 32) / d;
        endfunction

        function void axis_half(longint unsigned p, longint unsigned d,
                                output longint unsigned c, output longint unsigned t);
            longint unsigned q;
            q = 2 * p + d;
            c = q / (2 * d);
            t = ((q % (2 * d)) << 31) / d;
        endfunction

        // cells and weights of both grids; returns 1 when all corners are in the store
        function bit find_cells(logic [31:0] x, logic [31:0] y,
                                output longint unsigned uc, output longint unsigned ur,
                                output longint unsigned utx, output longint unsigned uty,
                                output longint unsigned vc, output longint unsigned vr,
                                output longint unsigned vtx, output longint unsigned vty);
            if (cell_w == 0 || cell_h == 0)
                return 0;
            axis_plain(x, cell_w, uc, utx);
            axis_half(y, cell_h, ur, uty);
            axis_half(x, cell_w, vc, vtx);
            axis_plain(y, cell_h, vr, vty);
            return uc + 1 < sgbs_pkg::GRID_COLUMNS && ur + 1 < sgbs_pkg::GRID_ROWS
                && vc + 1 < sgbs_pkg::GRID_COLUMNS && vr + 1 < sgbs_pkg::GRID_ROWS;
        endfunction

        function longint mix(longint a, longint b, longint unsigned t);
            longint s;
            s = longint'(64'h1_0000_0000 - t) * a + longint'(t) * b;
            return (s + 64'sd2147483648) >>> 32;
        endfunction

        function longint read_entry(bit vert, longint unsigned addr);
            logic signed [31:0] w;
            w = vert ? v_grid[addr] : h_grid[addr];
            return w;
        endfunction

        function longint bilinear(bit vert, longint unsigned c, longint unsigned r,
                                  longint unsigned tx, longint unsigned ty);
            longint unsigned base;
            base = c * sgbs_pkg::GRID_ROWS + r;
            return mix(mix(read_entry(vert, base),
                           read_entry(vert, base + sgbs_pkg::GRID_ROWS), tx),
                       mix(read_entry(vert, base + 1),
                           read_entry(vert, base + sgbs_pkg::GRID_ROWS + 1), tx), ty);
        endfunction

        // unwritten corner addresses a query would read
        function void missing(logic [31:0] x, logic [31:0] y, ref int hq[$], ref int vq[$]);
            longint unsigned uc, ur, utx, uty, vc, vr, vtx, vty;
            int b;
            hq.delete();
            vq.delete();
            if (!find_cells(x, y, uc, ur, utx, uty, vc, vr, vtx, vty))
                return;
            for (int k = 0; k < 4; k++)
            begin
                b = int'(uc * sgbs_pkg::GRID_ROWS + ur) +
                    (k[0] ? sgbs_pkg::GRID_ROWS : 0) + (k[1] ? 1 : 0);
                if (!h_set[b])
                    hq = {hq, b};
                b = int'(vc * sgbs_pkg::GRID_ROWS + vr) +
                    (k[0] ? sgbs_pkg::GRID_ROWS : 0) + (k[1] ? 1 : 0);
                if (!v_set[b])
                    vq = {vq, b};
            end
        endfunction

        function void note_input(logic [1:0] op, logic [5:0] col, logic [5:0] row,
                                 logic [31:0] val, logic [31:0] x, logic [31:0] y);
            longint unsigned uc, ur, utx, uty, vc, vr, vtx, vty;
            int a;
            sample_t s;
            a = int'(col) * sgbs_pkg::GRID_ROWS + int'(row);
            if (op == sgbs_pkg::OP_WRITE_H)
            begin
                h_grid[a] = val;
                h_set[a] = 1;
            end
            else if (op == sgbs_pkg::OP_WRITE_V)
            begin
                v_grid[a] = val;
                v_set[a] = 1;
            end
            else if (op == sgbs_pkg::OP_QUERY)
            begin
                s.h = '0;
                s.v = '0;
                s.oor = 1;
                if (find_cells(x, y, uc, ur, utx, uty, vc, vr, vtx, vty))
                begin
                    s.h = 32'(bilinear(0, uc, ur, utx, uty));
                    s.v = 32'(bilinear(1, vc, vr, vtx, vty));
                    s.oor = 0;
                end
                due = {due, s};
            end
        endfunction

        function void check_result(logic signed [31:0] h, logic signed [31:0] v, logic oor);
            sample_t s;
            if (due.size() == 0)
            begin
                $error("unexpected result item h=%0h v=%0h oor=%0b", h, v, oor);
                errors++;
                return;
            end
            s = due.pop_front();
            if (h !== s.h)
            begin
                $error("horizontal_velocity expected %0h actual %0h", s.h, h);
                errors++;
            end
            if (v !== s.v)
            begin
                $error("vertical_velocity expected %0h actual %0h", s.v, v);
                errors++;
            end
            if (oor !== s.oor)
            begin
                $error("out_of_range expected %0b actual %0b", s.oor, oor);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_write = 0;
    logic [sgbs_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_ready;
    logic [1:0] op = '0;
    logic [5:0] column = '0;
    logic [5:0] row = '0;
    logic signed [31:0] entry_value = '0;
    logic [31:0] query_x = '0;
    logic [31:0] query_y = '0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [31:0] horizontal_velocity;
    logic signed [31:0] vertical_velocity;
    logic out_of_range;

    velocity_board board = new();
    int burst_left = 0;
    int idle_cycles = 0;
    int sent = 0;
    bit hold_req = 0;
    int hold_left = 0;
    int ready_phase = 0;

    staggered_grid_bilinear_sampler u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .column(column), .row(row), .entry_value(entry_value),
        .query_x(query_x), .query_y(query_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .horizontal_velocity(horizontal_velocity),
        .vertical_velocity(vertical_velocity),
        .out_of_range(out_of_range)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(horizontal_velocity, vertical_velocity, out_of_range);
    end

    // receiver: long hold on request, otherwise free-run stretches alternating with random-stall stretches
    always @(posedge clk)
    begin
        ready_phase <= (ready_phase + 1) % 600;
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 0;
        end
        else if (hold_req)
        begin
            hold_req = 0;
            hold_left <= LONG_HOLD;
            out_ready <= 0;
        end
        else if (ready_phase < 200)
            out_ready <= 1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        int quiet;
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("staggered_grid_bilinear_sampler_tb failed");
            $finish;
        end
    end

    task automatic send(logic [1:0] o, logic [5:0] c, logic [5:0] r, logic [31:0] val,
                        logic [31:0] x, logic [31:0] y);
        if (burst_left == 0)
        begin
            idle_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (idle_cycles > 0)
            begin
                in_valid <= 0;
                repeat (idle_cycles) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1;
        op <= o;
        column <= c;
        row <= r;
        entry_value <= val;
        query_x <= x;
        query_y <= y;
        do @(posedge clk); while (!in_ready);
        board.note_input(o, c, r, val, x, y);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.due.size() > 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(logic [sgbs_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] d);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_write <= 0;
        board.set_reg(idx, d);
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_coord(logic [31:0] d);
        longint unsigned span;
        span = 63 * longint'(d);
        if (span > 64'hffff_ffff)
            span = 64'hffff_ffff;
        if ($urandom_range(0, 9) < 8)
            return 32'({$urandom, $urandom} % (span + 1));
        return $urandom;
    endfunction

    task automatic query(logic [31:0] x, logic [31:0] y);
        int hq[$];
        int vq[$];
        board.missing(x, y, hq, vq);
        foreach (hq[k])
            send(sgbs_pkg::OP_WRITE_H, 6'(hq[k] / sgbs_pkg::GRID_ROWS),
                 6'(hq[k] % sgbs_pkg::GRID_ROWS), rand_value(), 32'd0, 32'd0);
        foreach (vq[k])
            send(sgbs_pkg::OP_WRITE_V, 6'(vq[k] / sgbs_pkg::GRID_ROWS),
                 6'(vq[k] % sgbs_pkg::GRID_ROWS), rand_value(), 32'd0, 32'd0);
        send(sgbs_pkg::OP_QUERY, 6'($urandom), 6'($urandom), $urandom, x, y);
    endtask

    // sends items until about n more have been accepted
    task automatic random_items(int n);
        int stop;
        stop = sent + n;
        while (sent < stop)
        begin
            case ($urandom_range(0, 19))
                0: send(OP_UNUSED, 6'($urandom), 6'($urandom), $urandom, $urandom, $urandom);
                1, 2, 3, 4, 5, 6, 7:
                    send(($urandom_range(0, 1) != 0) ? sgbs_pkg::OP_WRITE_V
                                                     : sgbs_pkg::OP_WRITE_H,
                         6'($urandom), 6'($urandom), rand_value(), $urandom, $urandom);
                default: query(rand_coord(board.cell_w), rand_coord(board.cell_h));
            endcase
        end
    endtask

    initial
    begin
        logic [31:0] widths [7];
        logic [31:0] heights [7];
        widths  = '{32'h0001_0000, 32'd1, 32'hffff_ffff, 32'h0001_8000, 32'h0000_9000,
                    32'd0, 32'h0002_0000};
        heights = '{32'h0001_0000, 32'd1, 32'hffff_ffff, 32'h0000_9000, 32'h0001_8000,
                    32'h0001_0000, 32'd0};
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send(sgbs_pkg::OP_WRITE_H, 6'd0, 6'd0, 32'h7fff_ffff, 32'd0, 32'd0);
        send(sgbs_pkg::OP_WRITE_H, 6'd1, 6'd0, 32'h8000_0000, 32'd0, 32'd0);
        send(sgbs_pkg::OP_WRITE_H, 6'd0, 6'd1, 32'h8000_0000, 32'd0, 32'd0);
        send(sgbs_pkg::OP_WRITE_H, 6'd1, 6'd1, 32'h7fff_ffff, 32'd0, 32'd0);
        send(sgbs_pkg::OP_WRITE_V, 6'd63, 6'd63, 32'h8000_0000, 32'd0, 32'd0);
        send(sgbs_pkg::OP_WRITE_V, 6'd0, 6'd0, 32'h7fff_ffff, 32'd0, 32'd0);
        send(OP_UNUSED, 6'h3f, 6'h3f, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        query(32'd0, 32'd0);
        query(32'h0000_8000, 32'h0000_4000);
        query(32'h003e_ffff, 32'h003e_8000);
        query(32'h003f_0000, 32'd0);
        query(32'd0, 32'h003f_0000);
        query(32'hffff_ffff, 32'hffff_ffff);
        query(32'h0000_ffff, 32'h0000_ffff);
        drain();

        for (int p = 0; p < 7; p++)
        begin
            if (p > 0)
            begin
                write_reg(sgbs_pkg::CFG_CELL_WIDTH, widths[p]);
                write_reg(sgbs_pkg::CFG_CELL_HEIGHT, heights[p]);
            end
            random_items(40);
            if (p == 1)
                hold_req = 1;
            random_items(p < 5 ? 135 : 60);
            drain();
        end

        if (board.errors == 0 && board.due.size() == 0)
            $display("staggered_grid_bilinear_sampler_tb passed");
        else
            $display("staggered_grid_bilinear_sampler_tb failed");
        $finish;
    end
endmodule

// ----- sim.f -----
src/sgbs_pkg.sv
src/sgbs_ram.sv
src/sgbs_divider.sv
src/sgbs_lerp.sv
src/staggered_grid_bilinear_sampler.sv
sim/staggered_grid_bilinear_sampler_tb.sv
